### rtl/elev_pkg.sv
// Package: transaction payload types for the elevator request scheduler.
`default_nettype none

package elev_pkg;

    localparam int unsigned TRACK_W = 16;
    localparam int unsigned TOTAL_W = 17;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef struct packed {
        logic               command;
        logic [TRACK_W-1:0] request_track;
        logic [TRACK_W-1:0] head_position;
    } t_req;

    typedef struct packed {
        logic [TRACK_W-1:0] from_track;
        logic [TRACK_W-1:0] to_track;
        logic [TRACK_W-1:0] distance;
        logic [TOTAL_W-1:0] total_movement;
        logic               no_requests;
        logic               dropped_loads;
        logic               last;
    } t_res;

    typedef struct packed {
        logic load;
        logic empty;
        logic drop;
        logic last;
    } t_move_ctl;

endpackage

`default_nettype wire

### rtl/elev_stream_if.sv
// Interface: valid/ready channel carrying one typed payload.
`default_nettype none

interface elev_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/elevator_disk_request_scheduler_core.sv
// Top level: LOOK disk request scheduler around one sorted request memory.
//
//  channel | dir | payload                                   | handshake
//  i_req   | in  | command, request_track, head_position     | valid/ready
//  o_res   | out | from/to track, distance, total, flags     | valid/ready
//
// A load keeps the store sorted by insertion: each entry above the new track
// is read and shifted up one place (S_LRD, S_LCMP) until the track lands at
// the bottom or above an entry no greater than it. A run scans for the first
// request at or above the head (one read and compare per entry passed), then
// gives one move per read of the store (S_ERD, S_EMIT), as the store has a
// single read port. Input is held off until the run's last move is in the
// output register; o_res stalls only freeze the walk. Synchronous active-low
// reset clears the count and overflow flag; the store itself needs no clearing.
`default_nettype none

module elevator_disk_request_scheduler_core
    import elev_pkg::*;
#(
    parameter int unsigned MAX_BATCH = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    elev_stream_if.sink   i_req,
    elev_stream_if.source o_res
);

    localparam int unsigned AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int unsigned CW = $clog2(MAX_BATCH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LRD  = 3'd1;
    localparam logic [2:0] S_LCMP = 3'd2;
    localparam logic [2:0] S_SRD  = 3'd3;
    localparam logic [2:0] S_SCMP = 3'd4;
    localparam logic [2:0] S_ERD  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [TRACK_W-1:0] mem [MAX_BATCH];
    logic [TRACK_W-1:0] r_rdata;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_ovf, n_ovf;
    logic [TRACK_W-1:0] r_val, n_val;
    logic [AW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_start, n_start;
    logic               r_up, n_up;
    logic [TRACK_W-1:0] r_head, n_head;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [CW-1:0]      r_left, n_left;
    logic               r_empty, n_empty;
    logic               r_drop, n_drop;

    logic               w_we, w_re;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [TRACK_W-1:0] w_wdata;
    logic               w_acc;
    logic               w_free;
    logic [TOTAL_W-1:0] w_total;
    logic [CW-1:0]      w_knext;
    t_move_ctl          w_ctl;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_knext     = CW'(r_k) + CW'(1);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_val   = r_val;
        n_k     = r_k;
        n_n     = r_n;
        n_start = r_start;
        n_up    = r_up;
        n_head  = r_head;
        n_total = r_total;
        n_left  = r_left;
        n_empty = r_empty;
        n_drop  = r_drop;
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_waddr = r_k;
        w_raddr = r_k;
        w_wdata = r_val;
        w_ctl   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_req.data.command == CMD_LOAD) begin
                        if (r_cnt == CW'(MAX_BATCH)) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_val   = i_req.data.request_track;
                            n_k     = r_cnt[AW-1:0];
                            n_cnt   = r_cnt + CW'(1);
                            n_state = S_LRD;
                        end
                    end else begin
                        n_head  = i_req.data.head_position;
                        n_n     = r_cnt;
                        n_left  = r_cnt;
                        n_drop  = r_ovf;
                        n_total = '0;
                        n_empty = (r_cnt == '0);
                        n_k     = '0;
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_state = (r_cnt == '0) ? S_EMIT : S_SRD;
                    end
                end
            end
            S_LRD: begin
                // insert at the bottom directly, else look at the entry below
                if (r_k == '0) begin
                    w_we    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_k - AW'(1);
                    n_state = S_LCMP;
                end
            end
            S_LCMP: begin
                w_we = 1'b1;
                if (r_rdata > r_val) begin
                    w_wdata = r_rdata;
                    n_k     = r_k - AW'(1);
                    n_state = S_LRD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SRD: begin
                w_re    = 1'b1;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (r_rdata >= r_head) begin
                    n_start = CW'(r_k);
                    n_up    = 1'b1;
                    n_state = S_ERD;
                end else if (w_knext < r_n) begin
                    n_k     = w_knext[AW-1:0];
                    n_state = S_SRD;
                end else begin
                    // every request lies below the head: sweep down only
                    n_start = r_n;
                    n_up    = 1'b0;
                    n_k     = r_k;
                    n_state = S_ERD;
                end
            end
            S_ERD: begin
                w_re    = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_free) begin
                    w_ctl.load  = 1'b1;
                    w_ctl.empty = r_empty;
                    w_ctl.drop  = r_drop;
                    w_ctl.last  = r_empty || (r_left == CW'(1));
                    n_head      = r_rdata;
                    n_total     = w_total;
                    n_left      = r_left - CW'(1);
                    if (w_ctl.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ERD;
                        if (!r_up) begin
                            n_k = r_k - AW'(1);
                        end else if (w_knext < r_n) begin
                            n_k = w_knext[AW-1:0];
                        end else begin
                            // reverse at the highest request
                            n_up = 1'b0;
                            n_k  = AW'(r_start - CW'(1));
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_k     <= n_k;
        r_n     <= n_n;
        r_start <= n_start;
        r_up    <= n_up;
        r_head  <= n_head;
        r_total <= n_total;
        r_left  <= n_left;
        r_empty <= n_empty;
        r_drop  <= n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    elev_move u_move (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_from       (r_head),
        .i_to         (r_rdata),
        .i_total_prev (r_total),
        .o_free       (w_free),
        .o_total      (w_total),
        .o_res        (o_res)
    );

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_BATCH))
        else $error("request count beyond capacity");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.no_requests |-> o_res.data.last)
        else $error("empty run result not marked last");

    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_req.data.command == CMD_RUN && r_cnt == '0 |=> r_state == S_EMIT && r_empty)
        else $error("empty run did not go straight to its result");

    a_moves_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load && !r_empty |-> r_left != '0)
        else $error("move issued after the run was exhausted");

endmodule

`default_nettype wire

### rtl/elev_move.sv
// Move unit: distance and running total of one move, held in the output register.
`default_nettype none

module elev_move
    import elev_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_move_ctl          i_ctl,
    input  wire logic [TRACK_W-1:0] i_from,
    input  wire logic [TRACK_W-1:0] i_to,
    input  wire logic [TOTAL_W-1:0] i_total_prev,
    output logic                    o_free,
    output logic [TOTAL_W-1:0]      o_total,
    elev_stream_if.source           o_res
);

    logic               r_valid;
    t_res               r_res;
    logic [TRACK_W-1:0] w_dist;
    t_res               w_res;

    assign w_dist  = (i_to >= i_from) ? (i_to - i_from) : (i_from - i_to);
    assign o_total = i_total_prev + TOTAL_W'(w_dist);
    assign o_free  = !r_valid || o_res.ready;

    always_comb begin
        w_res = '0;
        w_res.dropped_loads = i_ctl.drop;
        w_res.last          = i_ctl.last;
        if (i_ctl.empty) begin
            w_res.no_requests = 1'b1;
        end else begin
            w_res.from_track     = i_from;
            w_res.to_track       = i_to;
            w_res.distance       = w_dist;
            w_res.total_movement = o_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid = r_valid;
    assign o_res.data  = r_res;

endmodule

`default_nettype wire

### dv/testbench.sv
// Testbench: self-checking stimulus and move prediction for the LOOK request scheduler.
`timescale 1ns / 100ps

module testbench;
    import elev_pkg::*;

    localparam int unsigned BATCH_DEPTH  = 64;
    localparam int unsigned PHASE_ITEMS  = 100;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam longint      LIMIT_NS     = 64'd2_500_000 * 12;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    elev_stream_if #(.T(t_req)) req_if ();
    elev_stream_if #(.T(t_res)) res_if ();

    elevator_disk_request_scheduler_core #(
        .MAX_BATCH(BATCH_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    // Predictor state: a copy of the batch as loaded, in arrival order.
    logic [TRACK_W-1:0] track_store [BATCH_DEPTH];
    int unsigned        track_count   = 0;
    logic               overflow_flag = 1'b0;

    t_req request_queue [$];
    t_res pending_moves [$];

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned mismatches        = 0;
    logic [TRACK_W-1:0] prev_track = '0;
    logic [TRACK_W-1:0] cluster_base = '0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        res_if.ready = 1'b0;
    end

    task automatic push_move(input logic [TRACK_W-1:0] from_t, input logic [TRACK_W-1:0] to_t,
                             inout logic [TOTAL_W-1:0] total, input logic fin);
        t_res m;
        logic [TRACK_W-1:0] d;
        d = (to_t >= from_t) ? to_t - from_t : from_t - to_t;
        total = total + TOTAL_W'(d);
        m = '0;
        m.from_track     = from_t;
        m.to_track       = to_t;
        m.distance       = d;
        m.total_movement = total;
        m.dropped_loads  = overflow_flag;
        m.last           = fin;
        pending_moves.push_back(m);
    endtask

    // Work out the moves one accepted transaction causes and queue them.
    task automatic schedule_request(input t_req r);
        logic [TRACK_W-1:0] srt [BATCH_DEPTH];
        logic [TRACK_W-1:0] v;
        logic [TRACK_W-1:0] pos;
        logic [TOTAL_W-1:0] total;
        t_res m;
        int n, s, k, j, emitted;
        if (r.command == CMD_LOAD) begin
            if (track_count < BATCH_DEPTH) begin
                track_store[track_count] = r.request_track;
                track_count++;
            end else begin
                overflow_flag = 1'b1;
            end
        end else if (track_count == 0) begin
            m = '0;
            m.no_requests   = 1'b1;
            m.dropped_loads = overflow_flag;
            m.last          = 1'b1;
            pending_moves.push_back(m);
            overflow_flag = 1'b0;
        end else begin
            n = track_count;
            for (k = 0; k < n; k++) begin
                srt[k] = track_store[k];
            end
            for (k = 1; k < n; k++) begin
                v = srt[k];
                j = k;
                while (j > 0 && srt[j-1] > v) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = v;
            end
            s = 0;
            while (s < n && srt[s] < r.head_position) s++;
            pos = r.head_position;
            total = '0;
            emitted = 0;
            // Sweep up from the head, then reverse just below it.
            for (k = s; k < n; k++) begin
                push_move(pos, srt[k], total, emitted + 1 == n);
                emitted++;
                pos = srt[k];
            end
            for (k = s; k > 0; k--) begin
                push_move(pos, srt[k-1], total, emitted + 1 == n);
                emitted++;
                pos = srt[k-1];
            end
            track_count   = 0;
            overflow_flag = 1'b0;
        end
    endtask

    // Driver: present the next pending request, hold it until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                schedule_request(req_if.data);
            end
            if (!req_if.valid || req_if.ready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    req_if.data  <= request_queue.pop_front();
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted move against the oldest expectation.
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                if (pending_moves.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 100)
                        $display("%0t: unexpected move, expected none, actual from=%0d to=%0d",
                                 $time, got.from_track, got.to_track);
                end else begin
                    want = pending_moves.pop_front();
                    if (got.from_track !== want.from_track || got.to_track !== want.to_track ||
                        got.distance !== want.distance ||
                        got.total_movement !== want.total_movement ||
                        got.no_requests !== want.no_requests ||
                        got.dropped_loads !== want.dropped_loads || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 100)
                            $display({"%0t: move mismatch, expected from=%0d to=%0d dist=%0d ",
                                      "total=%0d none=%0b drop=%0b last=%0b, actual from=%0d ",
                                      "to=%0d dist=%0d total=%0d none=%0b drop=%0b last=%0b"},
                                     $time, want.from_track, want.to_track, want.distance,
                                     want.total_movement, want.no_requests, want.dropped_loads,
                                     want.last, got.from_track, got.to_track, got.distance,
                                     got.total_movement, got.no_requests, got.dropped_loads,
                                     got.last);
                    end
                end
            end
            res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic queue_load(input logic [TRACK_W-1:0] trk);
        t_req r;
        r.command       = CMD_LOAD;
        r.request_track = trk;
        r.head_position = TRACK_W'($urandom);
        request_queue.push_back(r);
        prev_track = trk;
    endtask

    task automatic queue_run(input logic [TRACK_W-1:0] head);
        t_req r;
        r.command       = CMD_RUN;
        r.request_track = TRACK_W'($urandom);
        r.head_position = head;
        request_queue.push_back(r);
    endtask

    function automatic logic [TRACK_W-1:0] pick_track();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 45) return TRACK_W'($urandom);
        if (sel < 55) return ($urandom_range(1) != 0) ? '1 : '0;
        if (sel < 60) return ($urandom_range(1) != 0) ? TRACK_W'($urandom_range(7))
                                                      : TRACK_W'(16'hFFFF - $urandom_range(7));
        if (sel < 85) return cluster_base + TRACK_W'($urandom_range(200));
        return prev_track;
    endfunction

    // A batch of loads followed by a run; the head often lands on or among the requests.
    task automatic queue_batch(input int unsigned size, inout int unsigned items);
        int unsigned sel;
        logic [TRACK_W-1:0] head;
        cluster_base = TRACK_W'($urandom);
        for (int unsigned k = 0; k < size; k++) begin
            queue_load(pick_track());
        end
        sel = $urandom_range(99);
        if (sel < 50)      head = TRACK_W'($urandom);
        else if (sel < 70) head = cluster_base + TRACK_W'($urandom_range(200));
        else if (sel < 80) head = prev_track;
        else if (sel < 90) head = '0;
        else               head = '1;
        queue_run(head);
        items += size + 1;
    endtask

    task automatic wait_drained();
        while (request_queue.size() != 0 || req_if.valid || pending_moves.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int unsigned items;
        int unsigned sel;
        int unsigned size;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty run, duplicates and head on a request, all above, all below,
        // all equal, widest sweep.
        queue_run('1);
        queue_load('0);
        queue_load('1);
        queue_load('1);
        queue_load(16'd100);
        queue_load(16'd7);
        queue_run(16'd100);
        queue_load(16'd500);
        queue_load(16'd20);
        queue_run('0);
        queue_load(16'd10);
        queue_load(16'd30);
        queue_run('1);
        queue_load(16'd40000);
        queue_load(16'd40000);
        queue_run(16'd40000);
        queue_run('0);
        queue_load('1);
        queue_load('0);
        queue_run(16'd1);
        wait_drained();

        for (int unsigned ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
                default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
            endcase
            items = 0;
            // Overflow the batch early in the first and last phases.
            if (ph == 0 || ph == 3) queue_batch(BATCH_DEPTH + 6, items);
            while (items < PHASE_ITEMS) begin
                sel = $urandom_range(99);
                if (sel < 8)       size = 0;
                else if (sel < 73) size = $urandom_range(8, 1);
                else if (sel < 95) size = $urandom_range(40, 9);
                else               size = $urandom_range(BATCH_DEPTH + 6, BATCH_DEPTH - 1);
                queue_batch(size, items);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_moves.size() == 0) begin
            $display("elevator_disk_request_scheduler_core test passed");
        end else begin
            $display("elevator_disk_request_scheduler_core test failed");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("elevator_disk_request_scheduler_core test failed");
        $finish;
    end

endmodule

### files.f
rtl/elev_pkg.sv
rtl/elev_stream_if.sv
rtl/elev_move.sv
rtl/elevator_disk_request_scheduler_core.sv
dv/testbench.sv
